// ===== src/ttg_pkg.sv =====
// Package for the touch tap and hold gesture detector.
// Holds event codes, register indexes, reset values and the shared structs.
// No dependencies.
package ttg_pkg;

	localparam int DEFAULT_TIME_BITS = 16;
	localparam int REG_BITS          = 16;
	localparam int NUM_REGS          = 8;
	localparam int IDX_BITS          = 3;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_SINGLE = 3'd1,
		EV_MULTI  = 3'd2,
		EV_HOLD   = 3'd3,
		EV_LONG   = 3'd4
	} ev_kind_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_DEBOUNCE      = 3'd0,
		REG_HOLD          = 3'd1,
		REG_LONG_HOLD     = 3'd2,
		REG_TAP_GAP       = 3'd3,
		REG_HOLD_LINGER   = 3'd4,
		REG_LONG_LINGER   = 3'd5,
		REG_SINGLE_LINGER = 3'd6,
		REG_MULTI_LINGER  = 3'd7
	} reg_idx_t;

	localparam logic [REG_BITS-1:0] RST_DEBOUNCE      = 16'd30;
	localparam logic [REG_BITS-1:0] RST_HOLD          = 16'd1000;
	localparam logic [REG_BITS-1:0] RST_LONG_HOLD     = 16'd15000;
	localparam logic [REG_BITS-1:0] RST_TAP_GAP       = 16'd450;
	localparam logic [REG_BITS-1:0] RST_HOLD_LINGER   = 16'd800;
	localparam logic [REG_BITS-1:0] RST_LONG_LINGER   = 16'd2000;
	localparam logic [REG_BITS-1:0] RST_SINGLE_LINGER = 16'd2000;
	localparam logic [REG_BITS-1:0] RST_MULTI_LINGER  = 16'd2500;

	typedef struct packed {
		logic [REG_BITS-1:0] debounce_ms;
		logic [REG_BITS-1:0] hold_ms;
		logic [REG_BITS-1:0] long_hold_ms;
		logic [REG_BITS-1:0] tap_gap_ms;
		logic [REG_BITS-1:0] hold_linger_ms;
		logic [REG_BITS-1:0] long_hold_linger_ms;
		logic [REG_BITS-1:0] single_tap_linger_ms;
		logic [REG_BITS-1:0] multi_tap_linger_ms;
	} cfg_t;

	typedef struct packed {
		ev_kind_t            event_kind;
		logic [REG_BITS-1:0] linger_ticks;
		logic                touch_settled;
		ev_kind_t            gesture_kind;
	} result_t;

endpackage

// ===== src/ttg_if.sv =====
// Valid/ready channel interfaces for tick input words and result words.
// Depends on ttg_pkg for the field widths.
interface ttg_tick_if;
	logic valid;
	logic ready;
	logic raw_touch;
	logic gestures_on;

	modport source (output valid, output raw_touch, output gestures_on, input ready);
	modport sink   (input valid, input raw_touch, input gestures_on, output ready);
endinterface

interface ttg_result_if import ttg_pkg::*;;
	logic                valid;
	logic                ready;
	logic [2:0]          event_kind;
	logic [REG_BITS-1:0] linger_ticks;
	logic                touch_settled;
	logic [2:0]          gesture_kind;

	modport source (output valid, output event_kind, output linger_ticks,
		output touch_settled, output gesture_kind, input ready);
	modport sink   (input valid, input event_kind, input linger_ticks,
		input touch_settled, input gesture_kind, output ready);
endinterface

// ===== src/touch_tap_hold_gesture_detector.sv =====
// Touch tap and hold gesture detector, top level.
// Channels: tick (sink) carries raw_touch and gestures_on once per ms tick;
// result (source) returns exactly one word per tick word: event_kind,
// linger_ticks, touch_settled and gesture_kind.
// Configuration: cfg_we/cfg_index/cfg_data write one of eight 16-bit timing
// registers; write them only while no tick is in flight.
// A taken tick word is held in the input register; the gesture logic sits
// between the input register and the result register, and its result is
// loaded into the result register when that register is free or draining.
// Throughput: one tick word per cycle while result.ready is high; the
// input register and the result register form a two-stage pipeline that
// takes one more word while a result waits.
// Stall: while result.ready is low the result register holds its word and
// the input register fills; tick.ready drops only when both are full.
// Reset: arst_n clears all gesture state, loads the register defaults and
// empties both stages.
// Depends on ttg_pkg, ttg_if, ttg_cfg_regs and ttg_core.
module touch_tap_hold_gesture_detector import ttg_pkg::*; #(
	parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	ttg_tick_if.sink            tick,
	ttg_result_if.source        result,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic    raw_s1, on_s1;
	logic    adv;

	ttg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ttg_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.raw_touch   (raw_s1),
		.gestures_on (on_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// advance the stage-1 word when the result register is free or draining
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick.valid && tick.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			raw_s1 <= tick.raw_touch;
			on_s1  <= tick.gestures_on;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result.valid         = valid_s2;
	assign result.event_kind    = res_s2.event_kind;
	assign result.linger_ticks  = res_s2.linger_ticks;
	assign result.touch_settled = res_s2.touch_settled;
	assign result.gesture_kind  = res_s2.gesture_kind;

`ifndef SYNTHESIS
	a_stall_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(res_s2))
		else $error("result word lost during stall");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |-> !valid_s1 || adv)
		else $error("input register overwritten");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced word did not reach result register");
`endif

endmodule

// ===== src/ttg_cfg_regs.sv =====
// Configuration register file: eight 16-bit timing registers.
// Depends on ttg_pkg.
module ttg_cfg_regs import ttg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms          <= RST_DEBOUNCE;
			cfg_q.hold_ms              <= RST_HOLD;
			cfg_q.long_hold_ms         <= RST_LONG_HOLD;
			cfg_q.tap_gap_ms           <= RST_TAP_GAP;
			cfg_q.hold_linger_ms       <= RST_HOLD_LINGER;
			cfg_q.long_hold_linger_ms  <= RST_LONG_LINGER;
			cfg_q.single_tap_linger_ms <= RST_SINGLE_LINGER;
			cfg_q.multi_tap_linger_ms  <= RST_MULTI_LINGER;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:      cfg_q.debounce_ms          <= cfg_data;
				REG_HOLD:          cfg_q.hold_ms              <= cfg_data;
				REG_LONG_HOLD:     cfg_q.long_hold_ms         <= cfg_data;
				REG_TAP_GAP:       cfg_q.tap_gap_ms           <= cfg_data;
				REG_HOLD_LINGER:   cfg_q.hold_linger_ms       <= cfg_data;
				REG_LONG_LINGER:   cfg_q.long_hold_linger_ms  <= cfg_data;
				REG_SINGLE_LINGER: cfg_q.single_tap_linger_ms <= cfg_data;
				REG_MULTI_LINGER:  cfg_q.multi_tap_linger_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/ttg_core.sv =====
// Gesture state and per-tick update: debounce, hold timing, tap counting.
// Depends on ttg_pkg; fed by the input stage and the configuration registers.
module ttg_core import ttg_pkg::*; #(
	parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    raw_touch,
	input  logic    gestures_on,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int CMP_BITS = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	logic                 prev_raw_q;
	logic [TIME_BITS-1:0] stable_q;
	logic                 settled_q;
	logic [TIME_BITS-1:0] press_q;
	logic                 hold_q;
	logic [1:0]           tap_q;
	logic [TIME_BITS-1:0] gap_q;
	ev_kind_t             gest_q;

	logic [TIME_BITS-1:0] stable_n, press_n, gap_n;
	logic                 settled_n, hold_n;
	logic [1:0]           tap_n;
	ev_kind_t             gest_n, ev;
	logic [REG_BITS-1:0]  linger;

	function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
		return (v == TMAX) ? v : v + 1'b1;
	endfunction

	function automatic logic over(input logic [TIME_BITS-1:0] cnt,
		input logic [REG_BITS-1:0] lim);
		return CMP_BITS'(cnt) > CMP_BITS'(lim);
	endfunction

	always_comb begin
		stable_n  = (raw_touch != prev_raw_q) ? '0 : sat_inc(stable_q);
		press_n   = settled_q ? sat_inc(press_q) : press_q;
		gap_n     = sat_inc(gap_q);
		settled_n = settled_q;
		hold_n    = hold_q;
		tap_n     = tap_q;
		gest_n    = gest_q;
		ev        = EV_NONE;
		linger    = '0;

		if (over(stable_n, cfg.debounce_ms)) begin
			if (gestures_on && raw_touch && settled_q) begin
				if (over(press_n, cfg.long_hold_ms)) begin
					if (!hold_q || gest_q != EV_LONG) begin
						ev = EV_LONG;
					end
					hold_n = 1'b1;
					gest_n = EV_LONG;
				end else if (over(press_n, cfg.hold_ms) && !hold_q) begin
					hold_n = 1'b1;
					gest_n = EV_HOLD;
					ev     = EV_HOLD;
				end
			end

			if (raw_touch && !settled_q) begin
				settled_n = 1'b1;
				press_n   = '0;
				if (gestures_on) begin
					hold_n = 1'b0;
				end
			end else if (!raw_touch && settled_q) begin
				settled_n = 1'b0;
				if (gestures_on) begin
					if (hold_q) begin
						if (gest_q == EV_LONG) begin
							ev     = EV_LONG;
							linger = cfg.long_hold_linger_ms;
						end else begin
							ev     = EV_HOLD;
							linger = cfg.hold_linger_ms;
							gest_n = EV_HOLD;
						end
						hold_n = 1'b0;
					end else begin
						if (tap_q != 2'd2) begin
							tap_n = tap_q + 2'd1;
						end
						gap_n = '0;
					end
				end
			end
		end

		// close the tap sequence after a quiet gap; overrides a hold release
		if (gestures_on && tap_n != 2'd0 && !raw_touch && over(gap_n, cfg.tap_gap_ms)) begin
			if (tap_n == 2'd1) begin
				ev     = EV_SINGLE;
				linger = cfg.single_tap_linger_ms;
			end else begin
				ev     = EV_MULTI;
				linger = cfg.multi_tap_linger_ms;
			end
			gest_n = ev;
			tap_n  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b0;
			stable_q   <= '0;
			settled_q  <= 1'b0;
			press_q    <= '0;
			hold_q     <= 1'b0;
			tap_q      <= 2'd0;
			gap_q      <= '0;
			gest_q     <= EV_NONE;
		end else if (step) begin
			prev_raw_q <= raw_touch;
			stable_q   <= stable_n;
			settled_q  <= settled_n;
			press_q    <= press_n;
			hold_q     <= hold_n;
			tap_q      <= tap_n;
			gap_q      <= gap_n;
			gest_q     <= gest_n;
		end
	end

	assign res.event_kind    = ev;
	assign res.linger_ticks  = linger;
	assign res.touch_settled = settled_n;
	assign res.gesture_kind  = gest_n;

`ifndef SYNTHESIS
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q != 2'd3)
		else $error("tap count beyond saturation");

	a_raw_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (raw_touch != prev_raw_q) |=> stable_q == '0)
		else $error("stable count not cleared on raw change");

	a_off_keeps_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		step && !gestures_on |=> gest_q == $past(gest_q))
		else $error("gesture changed with gestures off");

	a_idle_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(settled_q) && $stable(tap_q) && $stable(hold_q))
		else $error("state moved without a step");
`endif

endmodule
